@@ rtl/cwsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Congestion window sender control package
// Phase codes, configuration register indexes, reset constants and the bit
// layout of the stream beats shared by the control block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwsc_pkg;

  // Sender phase as reported on the result beat.
  typedef enum logic [1:0] {
    PH_SLOW_START = 2'd0,
    PH_AVOIDANCE  = 2'd1,
    PH_RECOVERY   = 2'd2
  } phase_t;

  // Configuration register indexes.
  localparam logic CFG_TOTAL_PACKETS     = 1'b0;
  localparam logic CFG_INITIAL_THRESHOLD = 1'b1;

  // Number of slots in the go-back-N ring. Ring slots and tail wrapping are
  // taken from the low bits of a count, so the ring is a power of two.
  localparam int RING_DEPTH = 256;

  // Window arithmetic constants (window is unsigned Q8.8).
  localparam logic [15:0] ONE_Q           = 16'd256;
  localparam logic [7:0]  DUP_LIMIT       = 8'd3;
  localparam logic [7:0]  DUP_MAX         = 8'd255;
  localparam logic [7:0]  RESET_THRESHOLD = 8'd64;

  // Input beat layout.
  localparam int IN_TDATA_W = 32;

  // Output beat layout, lowest field first.
  localparam int OUT_TDATA_W       = 40;
  localparam int OUT_START_LSB     = 0;
  localparam int OUT_COUNT_LSB     = 8;
  localparam int OUT_RETX_IDX_LSB  = 16;
  localparam int OUT_PHASE_LSB     = 24;
  localparam int OUT_WINDOW_LSB    = 26;
  localparam int OUT_ALL_ACKED_BIT = 34;
  localparam int OUT_PAD_W         = OUT_TDATA_W - OUT_ALL_ACKED_BIT - 1;

endpackage

`default_nettype wire

@@ rtl/congestion_window_sender_control.sv @@
// ----------------------------------------------------------------------------
// Congestion window sender control
// Reno-style window control for a sender that keeps its packets in a
// go-back-N ring, built around one restoring divider.
// ----------------------------------------------------------------------------
// Each input beat carries either an acknowledgement (tuser low, tdata holding
// the cumulative acknowledged packet count) or a retransmission timeout tick
// (tuser high), and produces exactly one result beat. The block works on one
// beat at a time and holds s_tready low while it does. A timeout beat goes
// from idle straight to the finish state. An acknowledgement is classified
// and then has its span worked out; when congestion avoidance grows a nonzero
// window, one radix-2 divider that retires one quotient bit per cycle runs in
// between (17 steps) to form the Q8.8 reciprocal of the window, which is
// added to it before the span. The ring slot of a count and the wrapped tail
// index are the low bits of their values, since the ring depth is a power of
// two. A finished result sits in the output register, so the next input beat
// may be accepted while it waits to be taken; a later result is held back
// until the output register is free. Configuration writes are always taken
// and must only be issued while the block is idle; writing the initial
// threshold also loads the working threshold.
`timescale 1ns / 1ps
`default_nettype none

module congestion_window_sender_control (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] ack_count
  input  wire logic        s_tuser,   // [0] func: 0 ACK, 1 timeout tick
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] send_start, [15:8] send_count, [23:16] retransmit_index,
  // [25:24] phase_now, [33:26] window_packets, [34] all_acked, rest zero
  output logic [39:0]      m_tdata,
  output logic             m_tuser,   // [0] retransmit
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IDX_W  = $clog2(cwsc_pkg::RING_DEPTH);
  localparam int SPAN_W = 11;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(cwsc_pkg::RING_DEPTH - 1);
  localparam logic [15:0] WINDOW_CAP = 16'((cwsc_pkg::RING_DEPTH - 1) * 256);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ACK,
    ST_RECIP,
    ST_SPAN,
    ST_FINISH
  } state_t;

  state_t          state;

  // Architectural state.
  cwsc_pkg::phase_t phase;
  logic [15:0]      window;
  logic [7:0]       threshold;
  logic [7:0]       dup_count;
  logic [IDX_W-1:0] base_index;
  logic [IDX_W-1:0] tail_index;
  logic [31:0]      acked_total;
  logic [31:0]      total_packets;

  // Item and result holding registers.
  logic [31:0]      ack_value;
  logic [7:0]       res_start;
  logic [7:0]       res_count;
  logic             res_retx;
  logic [7:0]       res_retx_idx;

  // Reciprocal divider.
  logic [31:0]      div_dvd;
  logic [15:0]      div_den;
  logic [15:0]      div_rem;
  logic [16:0]      div_quo;
  logic [5:0]       div_cnt;
  logic [16:0]      div_shift;
  logic [16:0]      div_sub;
  logic             div_ge;
  logic [15:0]      div_rem_next;

  assign div_shift    = {div_rem, div_dvd[31]};
  assign div_ge       = div_shift >= {1'b0, div_den};
  assign div_sub      = div_shift - {1'b0, div_den};
  assign div_rem_next = div_ge ? div_sub[15:0] : div_shift[15:0];

  // Acknowledgement classification, valid in ST_ACK.
  logic [IDX_W-1:0] slot;
  logic             is_dup;
  logic             is_new;
  logic             below_cap;
  logic             recip_due;
  logic [7:0]       dup_inc;
  logic [7:0]       half_window;
  logic [15:0]      window_step;

  assign slot        = ack_value[IDX_W-1:0];
  assign is_dup      = slot == base_index;
  assign is_new      = (slot > base_index) ||
                       ((slot <= tail_index) && (tail_index < base_index));
  assign below_cap   = window < WINDOW_CAP;
  assign recip_due   = (phase == cwsc_pkg::PH_AVOIDANCE) && !is_dup && is_new &&
                       below_cap && (window != '0);
  assign dup_inc     = (dup_count == cwsc_pkg::DUP_MAX) ? dup_count : dup_count + 8'd1;
  assign half_window = {1'b0, window[15:9]};
  assign window_step = below_cap ? window + cwsc_pkg::ONE_Q : window;

  // Span to send, valid in ST_SPAN.
  logic [IDX_W:0]    tail_unwrap;
  logic [SPAN_W-1:0] span_diff;
  logic [32:0]       remaining;
  logic              rem_below;
  logic              send_now;
  logic [7:0]        send_n;
  logic [IDX_W-1:0]  tail_sum;

  assign tail_unwrap = (tail_index < base_index) ?
                       (IDX_W+1)'(tail_index) + (IDX_W+1)'(cwsc_pkg::RING_DEPTH) :
                       (IDX_W+1)'(tail_index);
  assign span_diff   = SPAN_W'(base_index) + SPAN_W'(window[15:8]) -
                       SPAN_W'(tail_unwrap);
  assign remaining   = {1'b0, total_packets} - {1'b0, acked_total};
  assign rem_below   = $signed(remaining) <
                       $signed({{(33-SPAN_W){span_diff[SPAN_W-1]}}, span_diff});
  assign send_now    = rem_below ? ($signed(remaining) > 33'sd0) :
                                   ($signed(span_diff) > 11'sd0);
  assign send_n      = rem_below ? remaining[7:0] : span_diff[7:0];
  assign tail_sum    = tail_index + IDX_W'(send_n);

  assign s_tready  = state == ST_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      phase         <= cwsc_pkg::PH_SLOW_START;
      window        <= cwsc_pkg::ONE_Q;
      threshold     <= cwsc_pkg::RESET_THRESHOLD;
      dup_count     <= '0;
      base_index    <= '0;
      tail_index    <= '0;
      acked_total   <= '0;
      total_packets <= '0;
    end else begin
      // A result loaded in ST_FINISH takes precedence over clearing the old one.
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ack_value <= s_tdata;
            if (s_tuser) begin
              // Timeout: resend the base slot and collapse the window.
              res_start    <= '0;
              res_count    <= '0;
              res_retx     <= 1'b1;
              res_retx_idx <= 8'(base_index);
              phase        <= cwsc_pkg::PH_SLOW_START;
              threshold    <= half_window;
              window       <= cwsc_pkg::ONE_Q;
              dup_count    <= '0;
              tail_index   <= (base_index == LAST_SLOT) ? '0 : base_index + 1'b1;
              state        <= ST_FINISH;
            end else begin
              res_retx     <= 1'b0;
              res_retx_idx <= '0;
              state        <= ST_ACK;
            end
          end
        end

        ST_DIVIDE: begin
          div_dvd <= {div_dvd[30:0], 1'b0};
          div_rem <= div_rem_next;
          div_quo <= {div_quo[15:0], div_ge};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            state <= ST_RECIP;
          end
        end

        ST_ACK: begin
          state <= recip_due ? ST_DIVIDE : ST_SPAN;
          if (phase == cwsc_pkg::PH_RECOVERY) begin
            if (is_dup) begin
              window <= window_step;
            end else if (is_new) begin
              acked_total <= ack_value;
              base_index  <= slot;
              dup_count   <= '0;
              window      <= {threshold, 8'd0};
              phase       <= cwsc_pkg::PH_AVOIDANCE;
            end
          end else if (is_dup) begin
            dup_count <= dup_inc;
            if (dup_inc == cwsc_pkg::DUP_LIMIT) begin
              // Third duplicate: fast retransmit from the base.
              tail_index <= base_index;
              phase      <= cwsc_pkg::PH_RECOVERY;
              threshold  <= half_window;
              window     <= {half_window + 8'd3, 8'd0};
            end
          end else if (is_new) begin
            acked_total <= ack_value;
            base_index  <= slot;
            dup_count   <= '0;
            if (phase == cwsc_pkg::PH_SLOW_START) begin
              window <= window_step;
              if (window_step >= {threshold, 8'd0}) begin
                phase <= cwsc_pkg::PH_AVOIDANCE;
              end
            end else if (below_cap) begin
              if (window == '0) begin
                window <= cwsc_pkg::ONE_Q;
              end else begin
                // Reciprocal 65536 / window, 17 quotient bits.
                div_dvd <= 32'h8000_0000;
                div_den <= window;
                div_rem <= '0;
                div_cnt <= 6'd17;
              end
            end
          end
        end

        ST_RECIP: begin
          window <= window + div_quo[15:0];
          state  <= ST_SPAN;
        end

        ST_SPAN: begin
          res_start <= 8'(tail_index);
          if (send_now) begin
            res_count  <= send_n;
            tail_index <= tail_sum;
          end else begin
            res_count <= '0;
          end
          state <= ST_FINISH;
        end

        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_retx;
            m_tdata  <= {{cwsc_pkg::OUT_PAD_W{1'b0}},
                         acked_total == total_packets,
                         window[15:8],
                         phase,
                         res_retx_idx,
                         res_count,
                         res_start};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase

      if (cfg_valid) begin
        unique case (cfg_index)
          cwsc_pkg::CFG_TOTAL_PACKETS:     total_packets <= cfg_data;
          cwsc_pkg::CFG_INITIAL_THRESHOLD: threshold     <= cfg_data[7:0];
          default:                         total_packets <= total_packets;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cwsc_checker.sv @@
// ----------------------------------------------------------------------------
// Congestion window sender control checker
// Port-level assertions on result beats and input flow, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser
);

  // The block handles one input beat at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a beat was in progress");

  // A timeout result sends no span and restarts slow start at one packet.
  a_timeout_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[cwsc_pkg::OUT_COUNT_LSB +: 8] == 8'd0 &&
      m_tdata[cwsc_pkg::OUT_START_LSB +: 8] == 8'd0 &&
      m_tdata[cwsc_pkg::OUT_PHASE_LSB +: 2] == cwsc_pkg::PH_SLOW_START &&
      m_tdata[cwsc_pkg::OUT_WINDOW_LSB +: 8] == 8'd1)
    else $error("timeout result carries wrong span, phase or window");

  // An acknowledgement result never names a slot to resend.
  a_ack_no_retx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[cwsc_pkg::OUT_RETX_IDX_LSB +: 8] == 8'd0)
    else $error("acknowledgement result with a resend index");

  // Fast recovery starts at threshold plus three and never shrinks: window >= 3.
  a_recovery_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[cwsc_pkg::OUT_PHASE_LSB +: 2] == cwsc_pkg::PH_RECOVERY |->
      m_tdata[cwsc_pkg::OUT_WINDOW_LSB +: 8] >= 8'd3)
    else $error("fast recovery window below three packets");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

endmodule

bind congestion_window_sender_control cwsc_checker u_cwsc_checker (.*);

`default_nettype wire

@@ tb/sv/congestion_window_sender_control_test.sv @@
// ----------------------------------------------------------------------------
// Congestion window sender control testbench
// Drives acknowledgement and timeout beats into the window controller, works
// out each result beat with an independent model of the Reno window rules and
// compares every result beat field by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module congestion_window_sender_control_test;
  import cwsc_pkg::*;

  localparam int RING = RING_DEPTH;
  localparam logic [15:0] WINDOW_CAP = 16'((RING - 1) * 256);

  // Quiet-cycle limit. The slowest correct gap between two accepted beats is
  // an ACK that runs the divider, plus a sender gap and a receiver stall, or
  // the long receiver hold. The limit is several times the worst of these.
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic        func;
    logic [31:0] ack_count;
  } ack_beat_t;

  // One planned result beat: the span to send, the resend slot and the
  // window state after the step.
  typedef struct packed {
    logic [7:0] start_idx;
    logic [7:0] span_len;
    logic       retx;
    logic [7:0] retx_idx;
    phase_t     phase;
    logic [7:0] window;
    logic       all_acked;
  } send_plan_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  congestion_window_sender_control u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Model copy of the sender state and its configuration.
  phase_t      p_phase = PH_SLOW_START;
  logic [15:0] p_window = ONE_Q;
  logic [7:0]  p_thresh = RESET_THRESHOLD;
  logic [7:0]  p_dups = '0;
  logic [7:0]  p_base = '0;
  logic [7:0]  p_tail = '0;
  logic [31:0] p_acked = '0;
  logic [31:0] p_total = '0;

  ack_beat_t  ack_feed[$];
  send_plan_t planned_sends[$];
  send_plan_t seen_want;

  logic [31:0] gen_acked = '0;
  int beats_queued = 0;
  int beats_taken = 0;
  int results_seen = 0;
  int timeouts_fed = 0;
  int recoveries = 0;
  int peak_window = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int rx_gap = 0;
  int long_left = 0;
  bit idling = 1'b1;
  bit hold_go = 1'b0;
  bit hold_started = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s at result %0d: got %0h, want %0h", field, results_seen,
             got, want);
    mismatches++;
  endtask

  // Applies one accepted beat to the model state and queues the result it
  // must produce.
  task automatic advance_sender(input logic func, input logic [31:0] ack_count);
    send_plan_t  r;
    logic [7:0]  slot;
    logic        fresh;
    logic [31:0] step;
    longint      b, t, last, rem, w;
    r = '0;
    if (func) begin
      // Timeout: resend the base slot and collapse the window to 1.0.
      r.retx = 1'b1;
      r.retx_idx = p_base;
      p_phase = PH_SLOW_START;
      p_thresh = p_window[15:8] >> 1;
      p_window = ONE_Q;
      p_dups = '0;
      p_tail = 8'((p_base + 1) % RING);
      timeouts_fed++;
    end else begin
      slot = 8'(ack_count % RING);
      // A slot past the base is new, and so is one at or below a tail that
      // has wrapped around below the base.
      fresh = (slot > p_base) || (slot <= p_tail && p_tail < p_base);
      if (p_phase == PH_SLOW_START || p_phase == PH_AVOIDANCE) begin
        if (slot == p_base) begin
          if (p_dups < DUP_MAX) p_dups = p_dups + 8'd1;
          if (p_dups == DUP_LIMIT) begin
            // Third duplicate: fast retransmit and enter fast recovery.
            p_tail = p_base;
            p_phase = PH_RECOVERY;
            p_thresh = p_window[15:8] >> 1;
            p_window = {p_thresh + 8'd3, 8'd0};
            recoveries++;
          end
        end else if (fresh) begin
          p_acked = ack_count;
          p_base = slot;
          p_dups = '0;
          if (p_window < WINDOW_CAP) begin
            if (p_phase == PH_SLOW_START) step = 32'(ONE_Q);
            else if (p_window == 16'd0) step = 32'(ONE_Q);
            else step = 32'd65536 / 32'(p_window);
            p_window = 16'(32'(p_window) + step);
          end
          if (p_phase == PH_SLOW_START && p_window >= {p_thresh, 8'd0})
            p_phase = PH_AVOIDANCE;
        end
      end else if (p_phase == PH_RECOVERY) begin
        if (slot == p_base) begin
          if (p_window < WINDOW_CAP) p_window = p_window + ONE_Q;
        end else if (fresh) begin
          p_acked = ack_count;
          p_base = slot;
          p_dups = '0;
          p_window = {p_thresh, 8'd0};
          p_phase = PH_AVOIDANCE;
        end
      end

      // Span to send: from the tail, unwrapped past the base, up to
      // base + window, cut to the packets still unacknowledged.
      r.start_idx = p_tail;
      if (p_acked != p_total) begin
        b = longint'(p_base);
        t = longint'(p_tail);
        if (t < b) t = t + longint'(RING);
        w = longint'(p_window[15:8]);
        last = b + w;
        rem = longint'(p_total) - longint'(p_acked);
        if (rem < last - t) last = t + rem;
        r.start_idx = 8'(t % RING);
        if (last > t) begin
          r.span_len = 8'(last - t);
          p_tail = 8'(last % RING);
        end else begin
          p_tail = r.start_idx;
        end
      end
    end
    r.phase = p_phase;
    r.window = p_window[15:8];
    r.all_acked = (p_acked == p_total);
    if (int'(p_window[15:8]) > peak_window) peak_window = int'(p_window[15:8]);
    planned_sends.push_back(r);
  endtask

  // Input driver. The current beat is predicted at the edge that accepts it;
  // a new beat is loaded whenever the slot is free and no gap is pending.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_sender(s_tuser, s_tdata);
        beats_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (ack_feed.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tuser <= ack_feed[0].func;
          s_tdata <= ack_feed[0].ack_count;
          void'(ack_feed.pop_front());
          if (idling && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready. A one-time long hold lets the block fill up and stall
  // its input; otherwise short random stalls while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_started) begin
      hold_started <= 1'b1;
      long_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (long_left != 0) begin
      long_left <= long_left - 1;
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (idling && $urandom_range(0, 4) == 0) rx_gap <= $urandom_range(1, 5);
    end
  end

  // Result monitor: every accepted result beat is checked against the oldest
  // planned send.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (planned_sends.size() == 0) begin
        flag_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
      end else begin
        seen_want = planned_sends.pop_front();
        if (m_tdata[OUT_START_LSB +: 8] != seen_want.start_idx)
          flag_mismatch("send_start", 32'(m_tdata[OUT_START_LSB +: 8]),
                        32'(seen_want.start_idx));
        if (m_tdata[OUT_COUNT_LSB +: 8] != seen_want.span_len)
          flag_mismatch("send_count", 32'(m_tdata[OUT_COUNT_LSB +: 8]),
                        32'(seen_want.span_len));
        if (m_tuser != seen_want.retx)
          flag_mismatch("retransmit", 32'(m_tuser), 32'(seen_want.retx));
        if (m_tdata[OUT_RETX_IDX_LSB +: 8] != seen_want.retx_idx)
          flag_mismatch("retransmit_index", 32'(m_tdata[OUT_RETX_IDX_LSB +: 8]),
                        32'(seen_want.retx_idx));
        if (m_tdata[OUT_PHASE_LSB +: 2] != seen_want.phase)
          flag_mismatch("phase_now", 32'(m_tdata[OUT_PHASE_LSB +: 2]),
                        32'(seen_want.phase));
        if (m_tdata[OUT_WINDOW_LSB +: 8] != seen_want.window)
          flag_mismatch("window_packets", 32'(m_tdata[OUT_WINDOW_LSB +: 8]),
                        32'(seen_want.window));
        if (m_tdata[OUT_ALL_ACKED_BIT] != seen_want.all_acked)
          flag_mismatch("all_acked", 32'(m_tdata[OUT_ALL_ACKED_BIT]),
                        32'(seen_want.all_acked));
        if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] != '0)
          flag_mismatch("padding", 32'(m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]), 32'd0);
      end
      results_seen++;
    end
  end

  // Watchdog on cycles in which no beat of any channel is accepted.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout after %0d quiet cycles", quiet_cycles);
    $display("tb: failure");
    $finish;
  end

  task automatic feed(input logic func, input logic [31:0] ack_count);
    ack_feed.push_back('{func: func, ack_count: ack_count});
    beats_queued++;
  endtask

  // Waits until every queued beat has been taken and every result has come
  // back, so that the block is idle.
  task automatic settle();
    while (ack_feed.size() != 0 || beats_taken != beats_queued ||
           planned_sends.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOTAL_PACKETS) begin
      p_total = value;
    end else begin
      p_thresh = value[7:0];
    end
    reg_writes++;
    @(negedge clk);
  endtask

  // Mostly well-formed ACK traffic: climbing cumulative counts, bursts of
  // duplicates that can trigger fast retransmit, and timeout ticks, with some
  // stale or wild counts mixed in. In climb mode every beat acks one more.
  task automatic queue_random(input int n, input bit climb_only);
    int          made;
    int          pick;
    int          reps;
    logic [31:0] next;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (climb_only || pick < 55) begin
        if (climb_only) next = gen_acked + 32'd1;
        else if ($urandom_range(0, 7) == 0) next = gen_acked + $urandom_range(5, 12);
        else next = gen_acked + $urandom_range(1, 3);
        // Land exactly on the total now and then so the transfer completes.
        if (!climb_only && gen_acked < p_total && next > p_total) next = p_total;
        feed(1'b0, next);
        gen_acked = next;
        made++;
      end else if (pick < 75) begin
        reps = $urandom_range(1, 5);
        repeat (reps) feed(1'b0, gen_acked);
        made += reps;
      end else if (pick < 82) begin
        feed(1'b1, $urandom());
        made++;
      end else if (pick < 92) begin
        feed(1'b0, gen_acked - $urandom_range(1, 300));
        made++;
      end else begin
        feed(1'b0, $urandom());
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] total_val, input bit relative,
                           input logic [7:0] thresh, input int n, input bit climb_only,
                           input bit end_timeout);
    settle();
    write_reg(CFG_TOTAL_PACKETS, relative ? p_acked + total_val : total_val);
    write_reg(CFG_INITIAL_THRESHOLD, {24'd0, thresh});
    gen_acked = p_acked;
    queue_random(n, climb_only);
    if (end_timeout) feed(1'b1, $urandom());
  endtask

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);

    // A duplicate at reset settings: nothing to send, all acknowledged.
    feed(1'b0, 32'd0);
    settle();
    write_reg(CFG_TOTAL_PACKETS, 32'd40);
    write_reg(CFG_INITIAL_THRESHOLD, 32'd4);
    // Slow start up to the threshold, then congestion avoidance growth.
    feed(1'b0, 32'd1);
    feed(1'b0, 32'd2);
    feed(1'b0, 32'd3);
    feed(1'b0, 32'd5);
    feed(1'b0, 32'd7);
    // Three duplicates give fast retransmit; a fourth grows the window in
    // recovery, and a new ACK ends recovery.
    feed(1'b0, 32'd7);
    feed(1'b0, 32'd7);
    feed(1'b0, 32'd7);
    feed(1'b0, 32'd7);
    feed(1'b0, 32'd9);
    feed(1'b1, 32'hFFFF_FFFF);
    feed(1'b0, 32'd12);
    // Reach the total exactly, then take a timeout with everything acked.
    feed(1'b0, 32'd40);
    feed(1'b1, 32'h0000_0000);
    // Triple duplicate at a window of one leaves a zero threshold, so the
    // next new ACK zeroes the window and the one after uses a 1.0 step.
    feed(1'b0, 32'd40);
    feed(1'b0, 32'd40);
    feed(1'b0, 32'd40);
    feed(1'b0, 32'd41);
    feed(1'b0, 32'd42);
    // Acknowledged count above the total, and the largest count.
    feed(1'b0, 32'hFFFF_FFFF);
    feed(1'b0, 32'd0);
    feed(1'b1, 32'h5A5A_A5A5);

    // Mixed traffic, ending on a timeout so the next phase climbs from 1.0.
    run_phase(32'd30, 1'b1, 8'd8, 50, 1'b0, 1'b1);
    // Long climb with the largest threshold and total: the window runs into
    // its cap, and the receiver holds off for a long stretch meanwhile.
    run_phase(32'hFFFF_FFFF, 1'b0, 8'd255, 270, 1'b1, 1'b0);
    hold_go = 1'b1;
    run_phase(32'd0, 1'b0, 8'd1, 30, 1'b0, 1'b0);
    run_phase(32'd100, 1'b1, 8'($urandom_range(2, 40)), 70, 1'b0, 1'b0);
    run_phase(32'd20, 1'b1, 8'd16, 70, 1'b0, 1'b0);

    // The last part runs with both sides at full rate.
    settle();
    idling = 1'b0;
    run_phase($urandom_range(10, 200), 1'b1, 8'($urandom_range(1, 255)), 70, 1'b0, 1'b0);
    run_phase(32'd50, 1'b1, 8'd32, 70, 1'b0, 1'b0);

    settle();
    repeat (70) @(posedge clk);
    if (planned_sends.size() != 0)
      flag_mismatch("results never delivered", planned_sends.size(), 32'd0);

    $display("covered %0d input beats (%0d timeout ticks), %0d results, %0d register writes",
             beats_taken, timeouts_fed, results_seen, reg_writes);
    $display("fast recovery entered %0d times, window peaked at %0d packets, %0d mismatches",
             recoveries, peak_window, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cwsc_pkg.sv
rtl/congestion_window_sender_control.sv
rtl/cwsc_checker.sv
tb/sv/congestion_window_sender_control_test.sv
